// ===== sv/pms_pkg.sv =====
package pms_pkg;

  localparam int ALPHABET_SIZE_DEF = 20;
  localparam int MAX_LEN_DEF       = 16;

  localparam int FUNC_W     = 2;
  localparam int LETTER_W   = 5;
  localparam int POS_W      = 4;
  localparam int COEF_W     = 32;
  localparam int SEQ_LEN_W  = 5;
  localparam int RESULT_W   = 40;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 1;

  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RST = 5'd9;
  localparam logic [COEF_W:0]      ONE_Q16     = 33'h0_0001_0000;
  localparam logic [COEF_W-1:0]    COEF_MAX    = 32'h7FFF_FFFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_LEN      = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCORE_OFFSET = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SCORE = 2'd1,
    FUNC_COUNT = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_COEF  = 1'b1;

  typedef struct packed {
    logic clr;
    logic accept;
    logic exec;
  } pms_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_out;
    logic out_valid;
  } pms_sts_t;

endpackage

// ===== sv/pms_ctrl.sv =====
module pms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  pms_pkg::pms_sts_t sts,
  output pms_pkg::pms_cmd_t cmd
);
  import pms_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_busy;

  assign out_busy  = sts.out_valid & ~out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd.clr    = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) & in_tvalid;
    cmd.exec   = (state_r == S_EXEC) & ~(sts.need_out & out_busy);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/pms_dp.sv =====
module pms_dp #(
  parameter int ALPHABET_SIZE = pms_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_LEN       = pms_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pms_pkg::pms_cmd_t                 cmd,
  output pms_pkg::pms_sts_t                 sts,
  input  logic [pms_pkg::FUNC_W-1:0]        in_func,
  input  logic [pms_pkg::LETTER_W-1:0]      in_letter,
  input  logic [pms_pkg::POS_W-1:0]         in_position,
  input  logic [pms_pkg::COEF_W-1:0]        in_value,
  input  logic                              cfg_we,
  input  logic [pms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pms_pkg::COEF_W-1:0]        cfg_wdata,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic                              out_kind,
  output logic [pms_pkg::RESULT_W-1:0]      out_result
);
  import pms_pkg::*;

  localparam int DEPTH = ALPHABET_SIZE * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [COEF_W-1:0] mem [DEPTH];
  logic [COEF_W-1:0] rdata_r;

  logic [AW-1:0]   clr_cnt_r;
  logic [PW-1:0]   lp_r;
  logic [RESULT_W-1:0] sum_r;
  logic [SEQ_LEN_W-1:0] seq_len_r;
  logic [COEF_W-1:0] offset_r;

  logic [FUNC_W-1:0] func_r;
  logic [COEF_W-1:0] value_r;
  logic [AW-1:0]     addr_r;
  logic              ok_r;
  logic              done_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [RESULT_W-1:0] out_data_r;

  logic        is_rw;
  logic [4:0]  letter_sel;
  logic [6:0]  pos_sel;
  logic [11:0] addr_full;
  logic        ok_in;
  logic [6:0]  eff_len;
  logic        done_in;

  logic [RESULT_W-1:0] coef_ext;
  logic [RESULT_W-1:0] term;
  logic [RESULT_W-1:0] sum_add;
  logic [RESULT_W-1:0] score;
  logic [COEF_W:0]     cnt33;
  logic [COEF_W-1:0]   cnt_sat;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [COEF_W-1:0] mem_wdata;

  always_comb begin
    is_rw      = (in_func == FUNC_WRITE) || (in_func == FUNC_READ);
    letter_sel = in_letter;
    pos_sel    = is_rw ? 7'(in_position) : 7'(lp_r);
    addr_full  = 12'(letter_sel) * 12'(MAX_LEN) + 12'(pos_sel);
    ok_in      = (6'(letter_sel) < 6'(ALPHABET_SIZE)) && (pos_sel < 7'(MAX_LEN));
    if (seq_len_r == '0) begin
      eff_len = 7'd1;
    end else if (7'(seq_len_r) > 7'(MAX_LEN)) begin
      eff_len = 7'(MAX_LEN);
    end else begin
      eff_len = 7'(seq_len_r);
    end
    done_in = (7'(lp_r) + 7'd1) >= eff_len;
  end

  always_comb begin
    coef_ext = {{(RESULT_W-COEF_W){rdata_r[COEF_W-1]}}, rdata_r};
    term     = ok_r ? coef_ext : '0;
    sum_add  = sum_r + term;
    score    = sum_add + {{(RESULT_W-COEF_W){offset_r[COEF_W-1]}}, offset_r};
    cnt33    = {rdata_r[COEF_W-1], rdata_r} + ONE_Q16;
    cnt_sat  = (~cnt33[COEF_W] & cnt33[COEF_W-1]) ? COEF_MAX : cnt33[COEF_W-1:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = value_r;
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.exec && ok_r) begin
      if (func_r == FUNC_WRITE) begin
        mem_we = 1'b1;
      end else if (func_r == FUNC_COUNT) begin
        mem_we    = 1'b1;
        mem_wdata = cnt_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.accept) rdata_r <= mem[AW'(addr_full)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_func;
      value_r <= in_value;
      addr_r  <= AW'(addr_full);
      ok_r    <= ok_in;
      done_r  <= done_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      lp_r        <= '0;
      sum_r       <= '0;
      seq_len_r   <= SEQ_LEN_RST;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr && !sts.clr_last) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SEQ_LEN:      seq_len_r <= cfg_wdata[SEQ_LEN_W-1:0];
          CFG_SCORE_OFFSET: offset_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.exec && sts.need_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.exec) begin
        case (func_r)
          FUNC_WRITE: begin
            lp_r  <= '0;
            sum_r <= '0;
          end
          FUNC_READ: begin
            lp_r  <= '0;
            sum_r <= '0;
          end
          FUNC_SCORE: begin
            if (done_r) begin
              lp_r  <= '0;
              sum_r <= '0;
            end else begin
              lp_r  <= lp_r + PW'(1);
              sum_r <= sum_add;
            end
          end
          FUNC_COUNT: begin
            if (done_r) begin
              lp_r  <= '0;
              sum_r <= '0;
            end else begin
              lp_r <= lp_r + PW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (func_r == FUNC_READ) begin
        out_kind_r <= KIND_COEF;
        out_data_r <= term;
      end else if (func_r == FUNC_SCORE && done_r) begin
        out_kind_r <= KIND_SCORE;
        out_data_r <= score;
      end
    end
  end

  always_comb begin
    sts.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
    sts.need_out  = (func_r == FUNC_READ) || ((func_r == FUNC_SCORE) && done_r);
    sts.out_valid = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_result = out_data_r;

endmodule

// ===== sv/position_matrix_scorer.sv =====
// The table read and the word are registered at the edge that accepts a word; in
// state S_EXEC the add, count update or table write follows, and for a word that
// makes a result the execute edge loads out_tvalid and the result. No new input word
// is taken before that execute, as in_tready is low in S_EXEC. A word that makes a
// result waits in S_EXEC while the previous result is not taken.
// Reset: synchronous, active low. A clearing pass then zeroes all
// ALPHABET_SIZE * MAX_LEN table entries (320 by default), with in_tready low.
module position_matrix_scorer #(
  parameter int ALPHABET_SIZE = pms_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_LEN       = pms_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pms_pkg::IN_DATA_W-1:0]     in_tdata,   // letter, position, value, zero pad
  input  logic [pms_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pms_pkg::OUT_DATA_W-1:0]    out_tdata,  // result_value
  output logic                              out_tuser,  // kind
  input  logic                              cfg_we,
  input  logic [pms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pms_pkg::COEF_W-1:0]        cfg_wdata
);
  import pms_pkg::*;

  pms_cmd_t cmd;
  pms_sts_t sts;

  logic [LETTER_W-1:0] in_letter;
  logic [POS_W-1:0]    in_position;
  logic [COEF_W-1:0]   in_value;

  assign in_letter   = in_tdata[LETTER_W-1:0];
  assign in_position = in_tdata[LETTER_W+POS_W-1:LETTER_W];
  assign in_value    = in_tdata[LETTER_W+POS_W+COEF_W-1:LETTER_W+POS_W];

  pms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pms_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_LEN       (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_tuser),
    .in_letter   (in_letter),
    .in_position (in_position),
    .in_value    (in_value),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_kind    (out_tuser),
    .out_result  (out_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("word accepted while another is in flight");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !(cmd.accept || cmd.exec))
    else $error("datapath busy during table clear");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.need_out) |=> out_tvalid)
    else $error("result not presented after execute");

  a_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.exec))
    else $error("accept and execute in the same cycle");

endmodule
